/* hw/rtl/integer_to_radix_digits_unit_macros.svh */
// Assertion macros used by the radix digit converter back end.
`ifndef INTEGER_TO_RADIX_DIGITS_UNIT_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ITRD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itrd assertion failed");
`define ITRD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itrd assertion failed");
`else
`define ITRD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ITRD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/itrd_pkg.sv */
// Package: constants, types and helper functions of the radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

   localparam int RADIX_W        = 6;
   localparam int DIGIT_W        = 6;
   localparam int CHAR_W         = 7;
   localparam int DEF_MAX_DIGITS = 32;
   localparam int DEF_VALUE_BITS = 31;
   localparam int BITS_PER_STEP  = 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_TOP   = 6'd35;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'h61;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_RD,
      BK_LD
   } back_state_type;

   function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] e;
      e = r;
      if (r < RADIX_MIN) begin
         e = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         e = RADIX_MAX;
      end
      return e;
   endfunction

   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] c;
      logic [CHAR_W-1:0]  g;
      c = (d > DIGIT_TOP) ? DIGIT_TOP : d;
      if (c < DIGIT_TEN) begin
         g = CHAR_ZERO + {1'b0, c};
      end else begin
         g = CHAR_LOWER_A + {1'b0, c - DIGIT_TEN};
      end
      return g;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/integer_to_radix_digits_unit.sv */
// Top level of the integer to radix digit string converter.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_value
//   rsp      out  rsp_valid/rsp_ready    rsp_digit_char, rsp_last
//   csr      in   csr_valid/csr_ready    csr_radix
//
// Each digit is produced by the division loop (eight quotient bits a cycle)
// and then read back from the digit RAM.
// Synchronous active-high reset; radix resets to ten.
// The two-entry queue keeps taking requests while the back end works or stalls, until it is full.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits_unit #(
   parameter int MAX_DIGITS = itrd_pkg::DEF_MAX_DIGITS,
   parameter int VALUE_BITS = itrd_pkg::DEF_VALUE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [VALUE_BITS-1:0]         req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [itrd_pkg::CHAR_W-1:0]        rsp_digit_char,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [itrd_pkg::RADIX_W-1:0]  csr_radix
);

   localparam int JOB_W = itrd_pkg::RADIX_W + VALUE_BITS;

   logic             q_full;
   logic             q_push;
   logic [JOB_W-1:0] q_in;
   logic             q_pop;
   logic             q_valid;
   logic [JOB_W-1:0] q_head;

   itrd_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_radix (csr_radix),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   itrd_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   itrd_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (q_valid),
      .job_radix      (q_head[JOB_W-1:VALUE_BITS]),
      .job_value      (q_head[VALUE_BITS-1:0]),
      .job_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

/* hw/rtl/itrd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module itrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/itrd_queue.sv */
// Short request queue between the front and the back of the converter.
`timescale 1ns / 1ps
`default_nettype none

module itrd_queue #(
   parameter int WIDTH = 37
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic      [WIDTH-1:0] head_data
);

   localparam int DEPTH = itrd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/itrd_front.sv */
// Front end: radix register, request intake and radix clamping.
`timescale 1ns / 1ps
`default_nettype none

module itrd_front #(
   parameter int VALUE_BITS = itrd_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [VALUE_BITS-1:0]                req_value,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [itrd_pkg::RADIX_W-1:0]         csr_radix,
   input  wire logic                                 q_full,
   output logic                                      q_push,
   output logic [itrd_pkg::RADIX_W+VALUE_BITS-1:0]   q_data
);

   logic [itrd_pkg::RADIX_W-1:0] radix_ff;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign q_data    = {itrd_pkg::eff_radix(radix_ff), req_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itrd_pkg::RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_radix;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/itrd_back.sv */
// Back end: digit-serial long division, digit store and reversed read-out.
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_radix_digits_unit_macros.svh"

module itrd_back #(
   parameter int MAX_DIGITS = itrd_pkg::DEF_MAX_DIGITS,
   parameter int VALUE_BITS = itrd_pkg::DEF_VALUE_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               job_valid,
   input  wire logic [itrd_pkg::RADIX_W-1:0]       job_radix,
   input  wire logic [VALUE_BITS-1:0]              job_value,
   output logic                                    job_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [itrd_pkg::CHAR_W-1:0]             rsp_digit_char,
   output logic                                    rsp_last
);

   localparam int BPS    = itrd_pkg::BITS_PER_STEP;
   localparam int STEPS  = (VALUE_BITS + BPS - 1) / BPS;
   localparam int PAD_W  = STEPS * BPS;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int DW     = itrd_pkg::DIGIT_W;
   localparam int RW     = itrd_pkg::RADIX_W;

   itrd_pkg::back_state_type state_ff, state_in;

   logic [PAD_W-1:0]  sh_ff, sh_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     radix_ff, radix_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [itrd_pkg::CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;

   logic [PAD_W-1:0]  sh_v;
   logic [DW:0]       part_v;
   logic [DW-1:0]     rem_v;
   logic              wr_en;
   logic [DW-1:0]     rd_digit;
   logic              out_load;

   // eight restoring division steps on the shifting dividend
   always_comb begin
      sh_v  = sh_ff;
      rem_v = rem_ff;
      for (int i = 0; i < BPS; i++) begin
         part_v = {rem_v, sh_v[PAD_W-1]};
         sh_v   = {sh_v[PAD_W-2:0], 1'b0};
         if (part_v >= {1'b0, radix_ff}) begin
            part_v  = part_v - {1'b0, radix_ff};
            sh_v[0] = 1'b1;
         end
         rem_v = part_v[DW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      job_pop      = 1'b0;
      wr_en        = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         itrd_pkg::BK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               sh_in    = PAD_W'(job_value);
               rem_in   = '0;
               radix_in = job_radix;
               step_in  = STEP_W'(STEPS);
               cnt_in   = '0;
               state_in = itrd_pkg::BK_DIV;
            end
         end
         itrd_pkg::BK_DIV: begin
            sh_in   = sh_v;
            rem_in  = rem_v;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               wr_en   = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               rem_in  = '0;
               step_in = STEP_W'(STEPS);
               if (sh_v == '0 || cnt_ff == CNT_W'(MAX_DIGITS - 1)) begin
                  idx_in   = cnt_ff[ADDR_W-1:0];
                  state_in = itrd_pkg::BK_RD;
               end
            end
         end
         itrd_pkg::BK_RD: begin
            state_in = itrd_pkg::BK_LD;
         end
         itrd_pkg::BK_LD: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load    = 1'b1;
               out_char_in = itrd_pkg::glyph(rd_digit);
               out_last_in = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = itrd_pkg::BK_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = itrd_pkg::BK_RD;
               end
            end
         end
         default: begin
            state_in = itrd_pkg::BK_IDLE;
         end
      endcase
      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   itrd_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_DIGITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (rem_v),
      .rd_addr (idx_ff),
      .rd_data (rd_digit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itrd_pkg::BK_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff       <= sh_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last       = out_last_ff;

   `ITRD_ASSERT_IMP(a_rem_below_radix, clock, reset, state_ff == itrd_pkg::BK_DIV, rem_ff < radix_ff)
   `ITRD_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_DIGITS))
   `ITRD_ASSERT_IMP(a_pop_idle, clock, reset, job_pop, state_ff == itrd_pkg::BK_IDLE)
   `ITRD_ASSERT_NXT(a_last_to_idle, clock, reset, out_load && idx_ff == '0, state_ff == itrd_pkg::BK_IDLE && rsp_valid && rsp_last)

endmodule

`default_nettype wire
